/* rtl/core/vct_pkg.sv */
// Shared types and constants of the virtual channel credit tracker.
// Used by vct_update and vc_credit_tracker_core; no dependencies.

package vct_pkg;

    localparam int NUM_VCS_DEF = 8;

    // Action codes of an input word
    typedef enum logic [1:0] {
        ACT_TAKE   = 2'd0,
        ACT_SEND   = 2'd1,
        ACT_CREDIT = 2'd2,
        ACT_QUERY  = 2'd3
    } action_t;

    // Error codes of a result word
    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_IN_USE    = 3'd1,
        ERR_FULL      = 3'd2,
        ERR_IDLE      = 3'd3,
        ERR_UNDERFLOW = 3'd4
    } err_t;

    // Configuration register indexes
    localparam logic [1:0] CFG_BUF_SIZE  = 2'd0;
    localparam logic [1:0] CFG_WAIT_TAIL = 2'd1;
    localparam logic [1:0] CFG_BUSY_FULL = 2'd2;

    typedef struct packed {
        logic [7:0] buf_size;
        logic       wait_tail;
        logic       busy_full;
    } cfg_t;

    // One channel entry as stored in the state memory
    typedef struct packed {
        logic [7:0] occ;
        logic       in_use;
        logic       tail_done;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        err_t       error_code;
        logic [7:0] occupancy;
        logic       channel_in_use;
        logic       tail_was_sent;
        logic       is_full;
        logic       is_empty;
        logic       available;
        logic       has_credit;
        logic       fits_packet;
        logic [3:0] active_count;
    } result_t;

    // Write-back decision of one update
    typedef struct packed {
        logic       commit;
        entry_t     entry;
        logic [3:0] active;
    } upd_t;

endpackage

/* rtl/core/vc_credit_tracker_core.sv */
// Top level of the virtual channel credit tracker: handshakes, state memory,
// config registers. Depends on vct_pkg, vct_ram and vct_update.
//
//  channel  | signals                                   | dir | handshake
//  ---------+-------------------------------------------+-----+-------------------
//  input    | action vc_index is_tail packet_size       | in  | in_valid/in_ready
//  result   | error_code .. active_count                | out | out_valid/out_ready
//  config   | cfg_index cfg_data                        | in  | cfg_we, no wait
//
// For each word, the accept edge issues the state memory read; the write-back
// edge writes the modified entry back and loads the result register.
// The registered read data of the memory puts these on separate edges.
// After reset every entry reads as zero through per-channel valid bits; no
// clearing pass is needed, so a word is accepted right after reset.
// A result held by out_ready low stalls only the write-back edge; the word in
// the read state waits there, holding in_ready low, until the result register
// frees up.

module vc_credit_tracker_core #(
    parameter int NUM_VCS = vct_pkg::NUM_VCS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [2:0]  vc_index,
    input  logic        is_tail,
    input  logic [7:0]  packet_size,
    // result words
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  error_code,
    output logic [7:0]  occupancy,
    output logic        channel_in_use,
    output logic        tail_was_sent,
    output logic        is_full,
    output logic        is_empty,
    output logic        available,
    output logic        has_credit,
    output logic        fits_packet,
    output logic [3:0]  active_count,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int ADDR_W = (NUM_VCS > 1) ? $clog2(NUM_VCS) : 1;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [1:0]          action_reg;
    logic                tail_reg;
    logic [7:0]          psize_reg;
    logic                in_range_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [NUM_VCS-1:0]  valid_reg;
    logic [NUM_VCS-1:0]  valid_next;
    logic [3:0]          active_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    vct_pkg::result_t    result_reg;
    vct_pkg::cfg_t       cfg_reg;

    logic                accept;
    logic                finish;
    logic                in_range;
    logic [31:0]         vc_ext;
    logic [ADDR_W-1:0]   addr;
    logic [vct_pkg::ENTRY_W-1:0] rdata;
    vct_pkg::entry_t     entry;
    vct_pkg::upd_t       upd;
    vct_pkg::result_t    result;

    // Input side: one word in flight at a time
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    // Write back once the result register is free or being drained
    assign finish   = (state_reg == S_READ) && (!out_valid_reg || out_ready);

    assign vc_ext   = 32'(vc_index);
    assign in_range = vc_ext < 32'(NUM_VCS);
    assign addr     = vc_ext[ADDR_W-1:0];

    vct_ram #(
        .WIDTH (vct_pkg::ENTRY_W),
        .DEPTH (NUM_VCS)
    ) u_state_ram (
        .clk   (clk),
        .we    (finish && upd.commit),
        .waddr (addr_reg),
        .wdata (upd.entry),
        .re    (accept),
        .raddr (addr),
        .rdata (rdata)
    );

    // Entries never written since reset read as zero
    assign entry = (in_range_reg && valid_reg[addr_reg]) ? vct_pkg::entry_t'(rdata) : '0;

    vct_update u_update (
        .action      (action_reg),
        .is_tail     (tail_reg),
        .packet_size (psize_reg),
        .in_range    (in_range_reg),
        .entry       (entry),
        .active      (active_reg),
        .cfg         (cfg_reg),
        .upd         (upd),
        .result      (result)
    );

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        valid_next     = valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                if (finish)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    if (upd.commit)
                    begin
                        valid_next[addr_reg] = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            active_reg    <= '0;
            result_reg    <= '0;
            action_reg    <= '0;
            tail_reg      <= 1'b0;
            psize_reg     <= '0;
            in_range_reg  <= 1'b0;
            addr_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            // Hold the word's fields for the write-back cycle
            if (accept)
            begin
                action_reg   <= action;
                tail_reg     <= is_tail;
                psize_reg    <= packet_size;
                in_range_reg <= in_range;
                addr_reg     <= addr;
            end
            if (finish)
            begin
                active_reg <= upd.active;
                result_reg <= result;
            end
        end
    end

    // Configuration registers; write them only while no word is in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.buf_size  <= 8'd8;
            cfg_reg.wait_tail <= 1'b0;
            cfg_reg.busy_full <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                vct_pkg::CFG_BUF_SIZE:  cfg_reg.buf_size  <= cfg_data;
                vct_pkg::CFG_WAIT_TAIL: cfg_reg.wait_tail <= cfg_data[0];
                vct_pkg::CFG_BUSY_FULL: cfg_reg.busy_full <= cfg_data[0];
                default:                cfg_reg           <= cfg_reg;
            endcase
        end
    end

    assign out_valid      = out_valid_reg;
    assign error_code     = result_reg.error_code;
    assign occupancy      = result_reg.occupancy;
    assign channel_in_use = result_reg.channel_in_use;
    assign tail_was_sent  = result_reg.tail_was_sent;
    assign is_full        = result_reg.is_full;
    assign is_empty       = result_reg.is_empty;
    assign available      = result_reg.available;
    assign has_credit     = result_reg.has_credit;
    assign fits_packet    = result_reg.fits_packet;
    assign active_count   = result_reg.active_count;

`ifndef ASSERT_OFF
    // An accepted word blocks the input until its write-back
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("input accepted while a word is in flight");

    // A new result only appears from the write-back cycle
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_READ))
        else $error("result raised without a write-back");

    // A channel reported in use is counted as active
    a_active_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && result_reg.channel_in_use |-> result_reg.active_count != 4'd0)
        else $error("channel in use with zero active count");

    // A flagged error leaves the stored entry untouched
    a_error_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        finish && result.error_code != vct_pkg::ERR_OK |-> !upd.commit)
        else $error("entry written on an error");
`endif

endmodule

/* rtl/core/vct_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module vct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/vct_update.sv */
// Action logic of the credit tracker: modify one channel entry, build the result.
// Depends on vct_pkg.

module vct_update (
    input  logic [1:0]     action,
    input  logic           is_tail,
    input  logic [7:0]     packet_size,
    input  logic           in_range,
    input  vct_pkg::entry_t entry,
    input  logic [3:0]     active,
    input  vct_pkg::cfg_t  cfg,
    output vct_pkg::upd_t  upd,
    output vct_pkg::result_t result
);

    vct_pkg::action_t act;
    vct_pkg::err_t    err;
    vct_pkg::entry_t  ent_n;
    logic [3:0]       act_cnt_n;
    logic             release_vc;
    logic             full_n;
    logic [8:0]       fit_sum;

    assign act = vct_pkg::action_t'(action);

    always_comb
    begin
        err        = vct_pkg::ERR_OK;
        ent_n      = entry;
        release_vc = 1'b0;
        act_cnt_n  = active;
        case (act)
            vct_pkg::ACT_TAKE:
            begin
                if (entry.in_use)
                begin
                    err = vct_pkg::ERR_IN_USE;
                end
                else
                begin
                    ent_n.in_use    = 1'b1;
                    ent_n.tail_done = 1'b0;
                    act_cnt_n       = active + 4'd1;
                end
            end
            vct_pkg::ACT_SEND:
            begin
                if (entry.occ >= cfg.buf_size)
                begin
                    err = vct_pkg::ERR_FULL;
                end
                else
                begin
                    ent_n.occ = entry.occ + 8'd1;
                    if (is_tail)
                    begin
                        ent_n.tail_done = 1'b1;
                        release_vc      = !cfg.wait_tail && entry.in_use;
                    end
                end
            end
            vct_pkg::ACT_CREDIT:
            begin
                if (cfg.wait_tail && !entry.in_use)
                begin
                    err = vct_pkg::ERR_IDLE;
                end
                else if (entry.occ == 8'd0)
                begin
                    err = vct_pkg::ERR_UNDERFLOW;
                end
                else
                begin
                    ent_n.occ  = entry.occ - 8'd1;
                    release_vc = cfg.wait_tail && (entry.occ == 8'd1)
                                 && entry.tail_done && entry.in_use;
                end
            end
            default:
            begin
                err = vct_pkg::ERR_OK;
            end
        endcase
        if (release_vc)
        begin
            ent_n.in_use = 1'b0;
            if (active != 4'd0)
            begin
                act_cnt_n = active - 4'd1;
            end
        end
    end

    assign full_n  = ent_n.occ >= cfg.buf_size;
    assign fit_sum = {1'b0, ent_n.occ} + {1'b0, packet_size};

    always_comb
    begin
        upd.commit = in_range && (err == vct_pkg::ERR_OK);
        upd.entry  = ent_n;
        upd.active = in_range ? act_cnt_n : active;

        result = '0;
        result.active_count = upd.active;
        if (in_range)
        begin
            result.error_code     = err;
            result.occupancy      = ent_n.occ;
            result.channel_in_use = ent_n.in_use;
            result.tail_was_sent  = ent_n.tail_done;
            result.is_full        = full_n;
            result.is_empty       = ent_n.occ == 8'd0;
            result.available      = !ent_n.in_use && (!cfg.busy_full || !full_n);
            result.has_credit     = !full_n;
            result.fits_packet    = !ent_n.in_use && (fit_sum <= {1'b0, cfg.buf_size});
        end
    end

endmodule

/* test/tb_vc_credit_tracker_core.sv */
// Self-checking testbench for vc_credit_tracker_core: directed and random words
// checked against a cycle-free predictor of the per-channel credit state.
// Depends on vct_pkg and the tracker RTL only.

module tb_vc_credit_tracker_core;

    localparam int NUM_CH         = 8;
    localparam int SETTLE_CYCLES  = 4;     // read and write-back steps plus margin
    localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
    localparam int MAX_REPORTS    = 10;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    logic [1:0] action;
    logic [2:0] vc_index;
    logic       is_tail;
    logic [7:0] packet_size;
    logic       out_valid;
    logic       out_ready;
    logic [2:0] error_code;
    logic [7:0] occupancy;
    logic       channel_in_use;
    logic       tail_was_sent;
    logic       is_full;
    logic       is_empty;
    logic       available;
    logic       has_credit;
    logic       fits_packet;
    logic [3:0] active_count;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [7:0] cfg_data;

    // Predicted channel state and the register copies it runs under
    logic [7:0] chan_occ       [NUM_CH];
    logic       chan_in_use    [NUM_CH];
    logic       chan_tail_done [NUM_CH];
    logic [3:0] chan_active;
    logic [7:0] cfg_size;
    logic       cfg_hold_tail;
    logic       cfg_busy_full;

    // Expected status of every accepted word, oldest first
    vct_pkg::result_t status_q [$];

    // Packet progress per channel, used to shape well-formed traffic
    int         flits_left [NUM_CH];

    int         send_idle_pct;
    int         recv_stall_pct;
    int         mismatches;
    int         quiet_cycles;

    vc_credit_tracker_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .action         (action),
        .vc_index       (vc_index),
        .is_tail        (is_tail),
        .packet_size    (packet_size),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .error_code     (error_code),
        .occupancy      (occupancy),
        .channel_in_use (channel_in_use),
        .tail_was_sent  (tail_was_sent),
        .is_full        (is_full),
        .is_empty       (is_empty),
        .available      (available),
        .has_credit     (has_credit),
        .fits_packet    (fits_packet),
        .active_count   (active_count),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Credit state predictor
    // ------------------------------------------------------------------

    // Free a channel; the active count never goes below zero.
    function automatic void release_channel(input logic [2:0] vc);
        if (chan_in_use[vc])
        begin
            chan_in_use[vc] = 1'b0;
            if (chan_active != 4'd0)
                chan_active = chan_active - 4'd1;
        end
    endfunction

    // Apply one word to the predicted state and return the channel status
    // as it stands afterward. A word that hits an error leaves state alone.
    function automatic vct_pkg::result_t predict_status(input vct_pkg::action_t act,
                                                        input logic [2:0] vc,
                                                        input logic tail,
                                                        input logic [7:0] psize);
        vct_pkg::result_t st;
        vct_pkg::err_t    err;
        logic             full;
        err = vct_pkg::ERR_OK;
        case (act)
            vct_pkg::ACT_TAKE:
            begin
                if (chan_in_use[vc])
                    err = vct_pkg::ERR_IN_USE;
                else
                begin
                    chan_in_use[vc]    = 1'b1;
                    chan_tail_done[vc] = 1'b0;
                    chan_active        = chan_active + 4'd1;
                end
            end
            vct_pkg::ACT_SEND:
            begin
                if (chan_occ[vc] >= cfg_size)
                    err = vct_pkg::ERR_FULL;
                else
                begin
                    chan_occ[vc] = chan_occ[vc] + 8'd1;
                    if (tail)
                    begin
                        // a tail on an idle channel only marks the flag
                        chan_tail_done[vc] = 1'b1;
                        if (!cfg_hold_tail)
                            release_channel(vc);
                    end
                end
            end
            vct_pkg::ACT_CREDIT:
            begin
                if (cfg_hold_tail && !chan_in_use[vc])
                    err = vct_pkg::ERR_IDLE;
                else if (chan_occ[vc] == 8'd0)
                    err = vct_pkg::ERR_UNDERFLOW;
                else
                begin
                    chan_occ[vc] = chan_occ[vc] - 8'd1;
                    // with hold-for-tail, the last credit after the tail frees it
                    if (cfg_hold_tail && chan_occ[vc] == 8'd0 && chan_tail_done[vc])
                        release_channel(vc);
                end
            end
            default:
            begin
            end
        endcase
        full              = (chan_occ[vc] >= cfg_size);
        st.error_code     = err;
        st.occupancy      = chan_occ[vc];
        st.channel_in_use = chan_in_use[vc];
        st.tail_was_sent  = chan_tail_done[vc];
        st.is_full        = full;
        st.is_empty       = (chan_occ[vc] == 8'd0);
        st.available      = !chan_in_use[vc] && (!cfg_busy_full || !full);
        st.has_credit     = !full;
        // nine-bit sum, so a large packet never wraps into a fit
        st.fits_packet    = !chan_in_use[vc] &&
                            (({1'b0, chan_occ[vc]} + {1'b0, psize}) <= {1'b0, cfg_size});
        st.active_count   = chan_active;
        return st;
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall, check every accepted result word
    // ------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch on %s: expected %0d, got %0d", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        vct_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (status_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("result word with no expected status");
            end
            else
            begin
                want = status_q.pop_front();
                check_field("error_code",     8'(want.error_code),     8'(error_code));
                check_field("occupancy",      want.occupancy,          occupancy);
                check_field("channel_in_use", 8'(want.channel_in_use), 8'(channel_in_use));
                check_field("tail_was_sent",  8'(want.tail_was_sent),  8'(tail_was_sent));
                check_field("is_full",        8'(want.is_full),        8'(is_full));
                check_field("is_empty",       8'(want.is_empty),       8'(is_empty));
                check_field("available",      8'(want.available),      8'(available));
                check_field("has_credit",     8'(want.has_credit),     8'(has_credit));
                check_field("fits_packet",    8'(want.fits_packet),    8'(fits_packet));
                check_field("active_count",   8'(want.active_count),   8'(active_count));
            end
        end
        // stall the result side at the current rate
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: end the run once nothing has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one word, hold it until accepted, then record its expected status.
    // Valid stays high on return so back-to-back words need no gap.
    task automatic send_word(input vct_pkg::action_t act, input logic [2:0] vc,
                             input logic tail, input logic [7:0] psize);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        action      <= act;
        vc_index    <= vc;
        is_tail     <= tail;
        packet_size <= psize;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        status_q.push_back(predict_status(act, vc, tail, psize));
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // Reprogram all three registers while the tracker is idle.
    task automatic set_config(input logic [7:0] slots, input logic hold_tail,
                              input logic busy_full);
        drain_results();
        write_reg(vct_pkg::CFG_BUF_SIZE,  slots);
        write_reg(vct_pkg::CFG_WAIT_TAIL, {7'd0, hold_tail});
        write_reg(vct_pkg::CFG_BUSY_FULL, {7'd0, busy_full});
        cfg_we <= 1'b0;
        // let the last write land before the next word is taken
        @(posedge clk);
        cfg_size      = slots;
        cfg_hold_tail = hold_tail;
        cfg_busy_full = busy_full;
    endtask

    // Mostly well-formed packets (take, flits, tail, credits) on random
    // channels, the rest fully random words.
    task automatic send_random_word();
        vct_pkg::action_t act;
        logic [2:0]       vc;
        logic             tail;
        logic [7:0]       psize;
        vc    = 3'($urandom_range(7));
        act   = vct_pkg::action_t'($urandom_range(3));
        tail  = 1'($urandom_range(1));
        psize = 8'($urandom_range(255));
        if ($urandom_range(99) < 75)
        begin
            tail  = 1'b0;
            // keep packet sizes around the fit boundary
            psize = 8'($urandom_range(cfg_size + 1));
            if (chan_occ[vc] != 8'd0 && $urandom_range(99) < 45)
                act = vct_pkg::ACT_CREDIT;
            else if (!chan_in_use[vc] && flits_left[vc] == 0)
            begin
                act = vct_pkg::ACT_TAKE;
                flits_left[vc] = $urandom_range(1, 10);
            end
            else if (chan_occ[vc] < cfg_size)
            begin
                act = vct_pkg::ACT_SEND;
                if (flits_left[vc] == 0)
                    flits_left[vc] = 1;
                tail = (flits_left[vc] == 1);
                flits_left[vc] = flits_left[vc] - 1;
            end
            else
                act = (chan_occ[vc] != 8'd0) ? vct_pkg::ACT_CREDIT : vct_pkg::ACT_QUERY;
        end
        send_word(act, vc, tail, psize);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every action under the reset settings: fit edges, double take,
    // immediate release on tail, underflow, tail on an idle channel.
    task automatic test_basic_actions();
        send_word(vct_pkg::ACT_QUERY,  3'd0, 1'b0, 8'd8);
        send_word(vct_pkg::ACT_QUERY,  3'd0, 1'b1, 8'd9);
        send_word(vct_pkg::ACT_QUERY,  3'd7, 1'b0, 8'd255);
        send_word(vct_pkg::ACT_TAKE,   3'd0, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_TAKE,   3'd0, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_SEND,   3'd0, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_SEND,   3'd0, 1'b1, 8'd3);
        send_word(vct_pkg::ACT_CREDIT, 3'd0, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_CREDIT, 3'd0, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_CREDIT, 3'd0, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_SEND,   3'd7, 1'b1, 8'd1);
        send_word(vct_pkg::ACT_TAKE,   3'd7, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_CREDIT, 3'd3, 1'b0, 8'd0);
    endtask

    // One-slot buffer, hold until the last credit, full means busy:
    // send to full, release on last credit, credit for an idle channel,
    // a plain flit to an idle channel.
    task automatic test_release_on_last_credit();
        set_config(8'd1, 1'b1, 1'b1);
        send_word(vct_pkg::ACT_TAKE,   3'd5, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_SEND,   3'd5, 1'b1, 8'd0);
        send_word(vct_pkg::ACT_SEND,   3'd5, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_CREDIT, 3'd5, 1'b0, 8'd1);
        send_word(vct_pkg::ACT_CREDIT, 3'd5, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_SEND,   3'd2, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_QUERY,  3'd2, 1'b0, 8'd0);
    endtask

    // Zero-slot buffer: every channel full, every flit refused.
    task automatic test_zero_buffer();
        set_config(8'd0, 1'b0, 1'b0);
        send_word(vct_pkg::ACT_SEND,  3'd1, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_QUERY, 3'd1, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_QUERY, 3'd6, 1'b0, 8'd1);
    endtask

    // Largest buffer: fill one channel to 255, overrun it, drain it fully,
    // underflow it, then close the packet.
    task automatic test_deep_fill();
        set_config(8'd255, 1'b0, 1'b1);
        send_word(vct_pkg::ACT_TAKE, 3'd4, 1'b0, 8'd0);
        while (chan_occ[4] < cfg_size)
            send_word(vct_pkg::ACT_SEND, 3'd4, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_SEND,  3'd4, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_QUERY, 3'd4, 1'b0, 8'd0);
        while (chan_occ[4] != 8'd0)
            send_word(vct_pkg::ACT_CREDIT, 3'd4, 1'b0, 8'd255);
        send_word(vct_pkg::ACT_CREDIT, 3'd4, 1'b0, 8'd0);
        send_word(vct_pkg::ACT_SEND,   3'd4, 1'b1, 8'd0);
        flits_left[4] = 0;
    endtask

    // Random traffic under one setting; halfway through, hold the input
    // side until every outstanding result is back.
    task automatic test_random_traffic(input logic [7:0] slots, input logic hold_tail,
                                       input logic busy_full, input int words);
        set_config(slots, hold_tail, busy_full);
        for (int i = 0; i < words; i++)
        begin
            if (i == words / 2)
                drain_results();
            send_random_word();
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        action         = vct_pkg::ACT_QUERY;
        vc_index       = 3'd0;
        is_tail        = 1'b0;
        packet_size    = 8'd0;
        out_ready      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = vct_pkg::CFG_BUF_SIZE;
        cfg_data       = 8'd0;
        mismatches     = 0;
        quiet_cycles   = 0;
        // reset values of the registers and the channel table
        cfg_size       = 8'd8;
        cfg_hold_tail  = 1'b0;
        cfg_busy_full  = 1'b0;
        chan_active    = 4'd0;
        foreach (chan_occ[i])
        begin
            chan_occ[i]       = 8'd0;
            chan_in_use[i]    = 1'b0;
            chan_tail_done[i] = 1'b0;
            flits_left[i]     = 0;
        end

        // sender idles more rarely than the receiver stalls
        send_idle_pct  = 32;
        recv_stall_pct = 45;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_basic_actions();
        test_release_on_last_credit();
        test_zero_buffer();
        test_random_traffic(8'd4, 1'b0, 1'b1, 130);
        test_random_traffic(8'd1, 1'b1, 1'b0, 130);

        // swap: sender idles more than the receiver stalls
        send_idle_pct  = 45;
        recv_stall_pct = 32;
        test_random_traffic(8'($urandom_range(2, 12)), 1'($urandom_range(1)),
                            1'($urandom_range(1)), 130);
        test_random_traffic(8'd255, 1'b1, 1'b1, 130);

        // full rate on both sides
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_deep_fill();
        test_random_traffic(8'($urandom_range(2, 16)), 1'b0, 1'($urandom_range(1)), 130);
        test_random_traffic(8'd6, 1'b1, 1'b0, 130);

        drain_results();
        if (mismatches == 0 && status_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* vc_credit_tracker_core.f */
rtl/core/vct_pkg.sv
rtl/core/vct_ram.sv
rtl/core/vct_update.sv
rtl/core/vc_credit_tracker_core.sv
test/tb_vc_credit_tracker_core.sv
